// ----- rtl/pairwise_contact_energy_assert.svh -----
// assertion macros for the pairwise contact energy block
`ifndef PAIRWISE_CONTACT_ENERGY_ASSERT_SVH
`define PAIRWISE_CONTACT_ENERGY_ASSERT_SVH

// same-cycle implication, reset masked
`define PCE_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, reset masked
`define PCE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/pce_pkg.sv -----
// shared types, constants and lookup tables for the pairwise contact energy block
package pce_pkg;

    localparam int MAX_RESIDUES = 256;
    localparam int ADDR_W       = $clog2(MAX_RESIDUES);
    localparam int CNT_W        = $clog2(MAX_RESIDUES + 1);
    localparam int LET_W        = 5;
    localparam int COORD_W      = 20;
    localparam int CUT_W        = 16;
    localparam int CUT2_W       = 2 * CUT_W;
    localparam int SUM_W        = 32;
    localparam int DIFF_W       = COORD_W + 1;
    localparam int SQ_W         = 2 * DIFF_W;
    localparam int D2_W         = SQ_W + 1;
    localparam int RT_W         = CUT_W;
    localparam int DIV_NW       = 28;
    localparam int DIV_DW       = 23;
    localparam int DIV_CW       = $clog2(DIV_NW + 1);
    localparam int RT_CW        = $clog2(RT_W + 1);

    localparam logic [CUT_W-1:0]  CUTOFF_RST = 16'd2560;
    localparam logic [CUT2_W-1:0] CUT2_RST   = 32'd6553600;
    localparam logic [6:0]        HYD_SCALE  = 7'd100;

    typedef struct packed {
        logic [LET_W-1:0]          letter;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } t_residue;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD,
        S_SQ,
        S_CMP,
        S_SQW,
        S_DHW,
        S_DEW,
        S_STORE,
        S_FIN
    } t_state;

    // hydrophobicity in tenths
    function automatic logic signed [6:0] hydro_rom(input logic [LET_W-1:0] l);
        logic signed [6:0] v;
        case (l)
            5'd0:  v = 7'sd18;
            5'd1:  v = -7'sd10;
            5'd2:  v = 7'sd25;
            5'd3:  v = -7'sd35;
            5'd4:  v = -7'sd35;
            5'd5:  v = 7'sd28;
            5'd6:  v = -7'sd4;
            5'd7:  v = -7'sd32;
            5'd8:  v = 7'sd45;
            5'd9:  v = -7'sd10;
            5'd10: v = -7'sd39;
            5'd11: v = 7'sd38;
            5'd12: v = 7'sd19;
            5'd13: v = -7'sd35;
            5'd14: v = -7'sd10;
            5'd15: v = -7'sd16;
            5'd16: v = -7'sd35;
            5'd17: v = -7'sd45;
            5'd18: v = -7'sd8;
            5'd19: v = -7'sd7;
            5'd20: v = -7'sd10;
            5'd21: v = 7'sd42;
            5'd22: v = -7'sd9;
            5'd23: v = -7'sd10;
            5'd24: v = -7'sd13;
            5'd25: v = -7'sd10;
            default: v = 7'sd0;
        endcase
        return v;
    endfunction

    // charge in halves
    function automatic logic signed [2:0] charge_rom(input logic [LET_W-1:0] l);
        logic signed [2:0] v;
        case (l)
            5'd1, 5'd3, 5'd4, 5'd9, 5'd14, 5'd20, 5'd23, 5'd25: v = -3'sd2;
            5'd7:         v = 3'sd1;
            5'd10, 5'd17: v = 3'sd2;
            default:      v = 3'sd0;
        endcase
        return v;
    endfunction

endpackage

// ----- rtl/pce_mem.sv -----
// residue store: one write port, one registered read port
module pce_mem (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [pce_pkg::ADDR_W-1:0] i_waddr,
    input  pce_pkg::t_residue          i_wdata,
    input  logic [pce_pkg::ADDR_W-1:0] i_raddr,
    output pce_pkg::t_residue          o_rdata
);

    pce_pkg::t_residue r_mem [pce_pkg::MAX_RESIDUES];
    pce_pkg::t_residue r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/pce_isqrt.sv -----
// bit-pair iterative integer square root, one result bit per cycle
module pce_isqrt (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [pce_pkg::CUT2_W-1:0] i_n,
    output logic                       o_done,
    output logic [pce_pkg::RT_W-1:0]   o_root
);

    // the partial result runs as wide as the operand until the last step
    logic [pce_pkg::CUT2_W-1:0] r_rem,  n_rem;
    logic [pce_pkg::CUT2_W-1:0] r_res,  n_res;
    logic [pce_pkg::CUT2_W-1:0] r_bit,  n_bit;
    logic [pce_pkg::RT_CW-1:0]  r_cnt,  n_cnt;
    logic                       r_run,  n_run;
    logic                       r_done, n_done;
    logic [pce_pkg::CUT2_W:0]   trial;

    always_comb begin
        n_rem  = r_rem;
        n_res  = r_res;
        n_bit  = r_bit;
        n_cnt  = r_cnt;
        n_run  = r_run;
        n_done = 1'b0;
        trial  = {1'b0, r_rem} - ({1'b0, r_res} + {1'b0, r_bit});
        if (i_start) begin
            n_rem = i_n;
            n_res = '0;
            n_bit = pce_pkg::CUT2_W'(1) << (pce_pkg::CUT2_W - 2);
            n_cnt = '0;
            n_run = 1'b1;
        end else if (r_run) begin
            if (!trial[pce_pkg::CUT2_W]) begin
                n_rem = trial[pce_pkg::CUT2_W-1:0];
                n_res = (r_res >> 1) + r_bit;
            end else begin
                n_res = r_res >> 1;
            end
            n_bit = r_bit >> 2;
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == pce_pkg::RT_CW'(pce_pkg::RT_W - 1)) begin
                n_run  = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_run  <= n_run;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_res <= n_res;
        r_bit <= n_bit;
    end

    assign o_done = r_done;
    assign o_root = r_res[pce_pkg::RT_W-1:0];

endmodule

// ----- rtl/pce_div.sv -----
// restoring unsigned divider, one quotient bit per cycle
module pce_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [pce_pkg::DIV_NW-1:0] i_num,
    input  logic [pce_pkg::DIV_DW-1:0] i_den,
    output logic                       o_done,
    output logic [pce_pkg::DIV_NW-1:0] o_quot
);

    logic [pce_pkg::DIV_NW-1:0] r_q,    n_q;
    logic [pce_pkg::DIV_DW:0]   r_rem,  n_rem;
    logic [pce_pkg::DIV_DW-1:0] r_den,  n_den;
    logic [pce_pkg::DIV_CW-1:0] r_cnt,  n_cnt;
    logic                       r_run,  n_run;
    logic                       r_done, n_done;
    logic [pce_pkg::DIV_DW+1:0] shifted;
    logic [pce_pkg::DIV_DW+1:0] diff;

    always_comb begin
        n_q     = r_q;
        n_rem   = r_rem;
        n_den   = r_den;
        n_cnt   = r_cnt;
        n_run   = r_run;
        n_done  = 1'b0;
        shifted = {r_rem, r_q[pce_pkg::DIV_NW-1]};
        diff    = shifted - (pce_pkg::DIV_DW+2)'(r_den);
        if (i_start) begin
            n_q   = i_num;
            n_rem = '0;
            n_den = i_den;
            n_cnt = '0;
            n_run = 1'b1;
        end else if (r_run) begin
            if (!diff[pce_pkg::DIV_DW+1]) begin
                n_rem = diff[pce_pkg::DIV_DW:0];
                n_q   = {r_q[pce_pkg::DIV_NW-2:0], 1'b1};
            end else begin
                n_rem = shifted[pce_pkg::DIV_DW:0];
                n_q   = {r_q[pce_pkg::DIV_NW-2:0], 1'b0};
            end
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == pce_pkg::DIV_CW'(pce_pkg::DIV_NW - 1)) begin
                n_run  = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_run  <= n_run;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_q   <= n_q;
        r_rem <= n_rem;
        r_den <= n_den;
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

// ----- rtl/pairwise_contact_energy.sv -----
// top level: residue store, pair sequencer, shared sqrt and divider, saturating sums
//
//  channel   direction  handshake              payload
//  item in   input      start && !busy         i_residue_letter, i_pos_x/y/z, i_last_residue
//  result    output     o_valid (one cycle)    o_hydro_energy, o_elec_energy, o_overflow
//  config    input      i_cfg_we               i_cfg_wdata (cutoff, Q8.8)
//
// residue j is paired against the j stored residues one after another; a pair outside
// the cutoff or at zero distance only has its squared distance formed, one inside it
// also takes a 16-step root, then two 28-step divisions on the one divider; then the
// item is stored; a last item then sets the result strobe and clears the chain state
// busy is high from acceptance until the block is ready again; results cannot be stalled
// synchronous active-low reset: cutoff returns to 10.0, store contents stay undefined
module pairwise_contact_energy (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [pce_pkg::LET_W-1:0]          i_residue_letter,
    input  logic signed [pce_pkg::COORD_W-1:0] i_pos_x,
    input  logic signed [pce_pkg::COORD_W-1:0] i_pos_y,
    input  logic signed [pce_pkg::COORD_W-1:0] i_pos_z,
    input  logic                               i_last_residue,
    input  logic                               i_cfg_we,
    input  logic [pce_pkg::CUT_W-1:0]          i_cfg_wdata,
    output logic                               o_valid,
    output logic signed [pce_pkg::SUM_W-1:0]   o_hydro_energy,
    output logic signed [pce_pkg::SUM_W-1:0]   o_elec_energy,
    output logic                               o_overflow
);

    `include "pairwise_contact_energy_assert.svh"

    localparam int TW = pce_pkg::SUM_W + 2;

    pce_pkg::t_state               r_state, n_state;
    logic [pce_pkg::CNT_W-1:0]     r_count, n_count;
    logic [pce_pkg::ADDR_W-1:0]    r_idx,   n_idx;
    logic [1:0]                    r_sq_cnt, n_sq_cnt;
    pce_pkg::t_residue             r_in,    n_in;
    logic                          r_last,  n_last;
    logic [pce_pkg::CUT_W-1:0]     r_cutoff;
    logic [pce_pkg::CUT2_W-1:0]    r_cut2;
    logic [pce_pkg::SQ_W-1:0]      r_sq,    n_sq;
    logic [pce_pkg::D2_W-1:0]      r_d2,    n_d2;
    logic signed [pce_pkg::SUM_W-1:0] r_hydro, n_hydro;
    logic signed [pce_pkg::SUM_W-1:0] r_elec,  n_elec;
    logic                          r_sat,   n_sat;
    logic                          r_full,  n_full;
    logic                          r_o_valid, n_o_valid;
    logic signed [pce_pkg::SUM_W-1:0] r_o_hydro, n_o_hydro;
    logic signed [pce_pkg::SUM_W-1:0] r_o_elec,  n_o_elec;
    logic                          r_o_ovf,   n_o_ovf;

    pce_pkg::t_residue             rd_data;
    logic                          mem_we;
    logic                          sqrt_start, sqrt_done;
    logic [pce_pkg::RT_W-1:0]      root;
    logic                          div_start, div_done;
    logic [pce_pkg::DIV_NW-1:0]    div_num, quot;
    logic [pce_pkg::DIV_DW-1:0]    div_den;

    logic signed [pce_pkg::DIFF_W-1:0] diff;
    logic signed [pce_pkg::SQ_W-1:0]   sq_full;
    logic signed [12:0]            hp;
    logic signed [3:0]             cp;
    logic [11:0]                   hp_mag;
    logic [2:0]                    cp_mag;
    logic [pce_pkg::DIV_DW-1:0]    hden;
    logic signed [TW-1:0]          term, acc_sum;
    logic signed [pce_pkg::SUM_W-1:0] acc_in, sat_val;
    logic                          sat_hit;
    logic                          last_pair;

    pce_mem u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_count[pce_pkg::ADDR_W-1:0]),
        .i_wdata (r_in),
        .i_raddr (r_idx),
        .o_rdata (rd_data)
    );

    pce_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sqrt_start),
        .i_n     (r_d2[pce_pkg::CUT2_W-1:0]),
        .o_done  (sqrt_done),
        .o_root  (root)
    );

    pce_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (quot)
    );

    // pair products from the two letters
    always_comb begin
        hp     = 13'(pce_pkg::hydro_rom(rd_data.letter)) * 13'(pce_pkg::hydro_rom(r_in.letter));
        cp     = 4'(pce_pkg::charge_rom(rd_data.letter)) * 4'(pce_pkg::charge_rom(r_in.letter));
        hp_mag = hp[12] ? 12'(-hp) : hp[11:0];
        cp_mag = cp[3] ? 3'(-cp) : cp[2:0];
        hden   = pce_pkg::DIV_DW'(root) * pce_pkg::DIV_DW'(pce_pkg::HYD_SCALE);
    end

    // one coordinate difference squared per cycle
    always_comb begin
        case (r_sq_cnt)
            2'd0:    diff = pce_pkg::DIFF_W'(r_in.x) - pce_pkg::DIFF_W'(rd_data.x);
            2'd1:    diff = pce_pkg::DIFF_W'(r_in.y) - pce_pkg::DIFF_W'(rd_data.y);
            default: diff = pce_pkg::DIFF_W'(r_in.z) - pce_pkg::DIFF_W'(rd_data.z);
        endcase
        sq_full = diff * diff;
    end

    // divider operands and saturating accumulate; hydro operands in the root wait state
    always_comb begin
        if (r_state == pce_pkg::S_SQW) begin
            div_num = pce_pkg::DIV_NW'({hp_mag, 16'd0}) + pce_pkg::DIV_NW'(hden >> 1);
            div_den = hden;
        end else begin
            div_num = pce_pkg::DIV_NW'({cp_mag, 12'd0}) + pce_pkg::DIV_NW'(root >> 1);
            div_den = pce_pkg::DIV_DW'(root);
        end
        if (r_state == pce_pkg::S_DHW) begin
            acc_in = r_hydro;
            term   = hp[12] ? -TW'(quot) : TW'(quot);
        end else begin
            acc_in = r_elec;
            term   = cp[3] ? -TW'(quot) : TW'(quot);
        end
        acc_sum = TW'(acc_in) + term;
        sat_hit = 1'b0;
        sat_val = acc_sum[pce_pkg::SUM_W-1:0];
        if (acc_sum > TW'(32'sh7fffffff)) begin
            sat_hit = 1'b1;
            sat_val = 32'sh7fffffff;
        end else if (acc_sum < -TW'(33'sh080000000)) begin
            sat_hit = 1'b1;
            sat_val = 32'sh80000000;
        end
    end

    assign last_pair = (pce_pkg::CNT_W'(r_idx) + 1'b1) == r_count;

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_idx      = r_idx;
        n_sq_cnt   = r_sq_cnt;
        n_in       = r_in;
        n_last     = r_last;
        n_sq       = r_sq;
        n_d2       = r_d2;
        n_hydro    = r_hydro;
        n_elec     = r_elec;
        n_sat      = r_sat;
        n_full     = r_full;
        n_o_valid  = 1'b0;
        n_o_hydro  = r_o_hydro;
        n_o_elec   = r_o_elec;
        n_o_ovf    = r_o_ovf;
        mem_we     = 1'b0;
        sqrt_start = 1'b0;
        div_start  = 1'b0;
        case (r_state)
            pce_pkg::S_IDLE: begin
                if (start) begin
                    n_in.letter = i_residue_letter;
                    n_in.x      = i_pos_x;
                    n_in.y      = i_pos_y;
                    n_in.z      = i_pos_z;
                    n_last      = i_last_residue;
                    n_idx       = '0;
                    if (r_count >= pce_pkg::CNT_W'(pce_pkg::MAX_RESIDUES)) begin
                        n_full  = 1'b1;
                        n_state = i_last_residue ? pce_pkg::S_FIN : pce_pkg::S_IDLE;
                    end else if (r_count == '0) begin
                        n_state = pce_pkg::S_STORE;
                    end else begin
                        n_state = pce_pkg::S_RD;
                    end
                end
            end
            pce_pkg::S_RD: begin
                // read data for r_idx lands at this edge
                n_sq_cnt = '0;
                n_d2     = '0;
                n_state  = pce_pkg::S_SQ;
            end
            pce_pkg::S_SQ: begin
                n_sq = sq_full;
                if (r_sq_cnt != 2'd0) begin
                    n_d2 = r_d2 + pce_pkg::D2_W'(r_sq);
                end
                n_sq_cnt = r_sq_cnt + 1'b1;
                if (r_sq_cnt == 2'd3) begin
                    n_state = pce_pkg::S_CMP;
                end
            end
            pce_pkg::S_CMP: begin
                if (r_d2 == '0 || r_d2 >= pce_pkg::D2_W'(r_cut2)) begin
                    if (last_pair) begin
                        n_state = pce_pkg::S_STORE;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = pce_pkg::S_RD;
                    end
                end else begin
                    sqrt_start = 1'b1;
                    n_state    = pce_pkg::S_SQW;
                end
            end
            pce_pkg::S_SQW: begin
                if (sqrt_done) begin
                    div_start = 1'b1;
                    n_state   = pce_pkg::S_DHW;
                end
            end
            pce_pkg::S_DHW: begin
                if (div_done) begin
                    n_hydro   = sat_val;
                    n_sat     = r_sat | sat_hit;
                    div_start = 1'b1;
                    n_state   = pce_pkg::S_DEW;
                end
            end
            pce_pkg::S_DEW: begin
                if (div_done) begin
                    n_elec = sat_val;
                    n_sat  = r_sat | sat_hit;
                    if (last_pair) begin
                        n_state = pce_pkg::S_STORE;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = pce_pkg::S_RD;
                    end
                end
            end
            pce_pkg::S_STORE: begin
                mem_we  = 1'b1;
                n_count = r_count + 1'b1;
                n_state = r_last ? pce_pkg::S_FIN : pce_pkg::S_IDLE;
            end
            pce_pkg::S_FIN: begin
                n_o_valid = 1'b1;
                n_o_hydro = r_hydro;
                n_o_elec  = r_elec;
                n_o_ovf   = r_sat | r_full;
                n_count   = '0;
                n_hydro   = '0;
                n_elec    = '0;
                n_sat     = 1'b0;
                n_full    = 1'b0;
                n_state   = pce_pkg::S_IDLE;
            end
            default: begin
                n_state = pce_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= pce_pkg::S_IDLE;
            r_count   <= '0;
            r_hydro   <= '0;
            r_elec    <= '0;
            r_sat     <= 1'b0;
            r_full    <= 1'b0;
            r_o_valid <= 1'b0;
            r_cutoff  <= pce_pkg::CUTOFF_RST;
            r_cut2    <= pce_pkg::CUT2_RST;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_hydro   <= n_hydro;
            r_elec    <= n_elec;
            r_sat     <= n_sat;
            r_full    <= n_full;
            r_o_valid <= n_o_valid;
            if (i_cfg_we) begin
                r_cutoff <= i_cfg_wdata;
            end
            r_cut2 <= r_cutoff * r_cutoff;
        end
        r_idx     <= n_idx;
        r_sq_cnt  <= n_sq_cnt;
        r_in      <= n_in;
        r_last    <= n_last;
        r_sq      <= n_sq;
        r_d2      <= n_d2;
        r_o_hydro <= n_o_hydro;
        r_o_elec  <= n_o_elec;
        r_o_ovf   <= n_o_ovf;
    end

    assign busy           = (r_state != pce_pkg::S_IDLE);
    assign o_valid        = r_o_valid;
    assign o_hydro_energy = r_o_hydro;
    assign o_elec_energy  = r_o_elec;
    assign o_overflow     = r_o_ovf;

    `PCE_ASSERT_NEXT(a_strobe_single, i_clk, i_rst_n, o_valid, !o_valid, "result strobe held")
    `PCE_ASSERT_NEXT(a_fin_clears, i_clk, i_rst_n, r_state == pce_pkg::S_FIN,
        r_count == '0 && r_hydro == '0 && r_elec == '0, "chain state not cleared")
    `PCE_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1,
        r_count <= pce_pkg::CNT_W'(pce_pkg::MAX_RESIDUES), "residue count beyond store")
    `PCE_ASSERT_NOW(a_units_exclusive, i_clk, i_rst_n, sqrt_done, !div_done,
        "root and divider finished together")

endmodule
